// ===== design/ftpp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the file transfer packet parser.
// No dependencies; used by the front, back and top level.
package ftpp_pkg;

	localparam logic [7:0] BYTE_DATA  = 8'h01;
	localparam logic [7:0] BYTE_START = 8'h02;
	localparam logic [7:0] BYTE_END   = 8'h03;
	localparam logic [7:0] FTYPE_SIZE = 8'h00;
	localparam logic [7:0] FTYPE_NAME = 8'h01;

	typedef enum logic [1:0] {
		KIND_IGNORED = 2'd0,
		KIND_START   = 2'd1,
		KIND_DATA    = 2'd2,
		KIND_END     = 2'd3
	} kind_t;

	// work the back end does for one item
	typedef enum logic [2:0] {
		OP_NONE       = 3'd0,
		OP_PAY        = 3'd1,
		OP_NAME       = 3'd2,
		OP_SIZE_CLR   = 3'd3,
		OP_SIZE_SHIFT = 3'd4,
		OP_SEQ        = 3'd5
	} op_t;

	typedef struct packed {
		op_t        op;
		logic       sel_end;    // size op targets the end size
		logic [7:0] data;
		kind_t      kind;
		logic       done;
		logic       data_done;
		logic       end_done;
	} cmd_t;

	typedef struct packed {
		logic        payload_valid;
		logic [7:0]  payload_byte;
		logic        name_valid;
		logic [7:0]  name_byte;
		kind_t       packet_kind;
		logic        packet_done;
		logic [7:0]  sequence_number;
		logic [31:0] declared_size;
		logic [31:0] bytes_received;
		logic [15:0] packets_received;
		logic        size_mismatch;
		logic        transfer_done;
	} res_t;

endpackage

// ===== design/ftpp_fifo.sv =====
`timescale 1ns / 1ps
// Small first-in first-out queue of WIDTH-bit items.
// No package dependencies; used between front and back and at the output.
module ftpp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== design/ftpp_front.sv =====
`timescale 1ns / 1ps
// Front end: packet framing state machine that classifies each byte
// into a command for the back end. Depends on ftpp_pkg.
module ftpp_front
	import ftpp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] data_byte,
	input  logic       end_of_packet,
	output cmd_t       cmd
);
	typedef enum logic [9:0] {
		PH_KIND = 10'b0000000001,
		PH_SKIP = 10'b0000000010,
		PH_TYPE = 10'b0000000100,
		PH_LEN  = 10'b0000001000,
		PH_VAL  = 10'b0000010000,
		PH_SEQ  = 10'b0000100000,
		PH_LHI  = 10'b0001000000,
		PH_LLO  = 10'b0010000000,
		PH_PAY  = 10'b0100000000,
		PH_DONE = 10'b1000000000
	} phase_t;

	phase_t      phase_q, phase_d;
	logic        started_q, started_d;
	kind_t       kind_q, kind_d;
	logic [7:0]  ftype_q, ftype_d;
	logic [15:0] left_q, left_d;
	logic [15:0] left_dec, left_or;

	assign left_dec = left_q - 16'd1;
	assign left_or  = left_q | {8'h00, data_byte};

	always_comb begin
		phase_d     = phase_q;
		started_d   = started_q;
		kind_d      = kind_q;
		ftype_d     = ftype_q;
		left_d      = left_q;
		cmd         = '0;
		cmd.op      = OP_NONE;
		cmd.kind    = KIND_IGNORED;
		cmd.data    = data_byte;
		cmd.sel_end = (kind_q != KIND_START);
		case (phase_q)
			PH_KIND: begin
				if (data_byte == BYTE_START && !started_q) begin
					kind_d    = KIND_START;
					started_d = 1'b1;
					phase_d   = PH_TYPE;
				end else if (data_byte == BYTE_END && started_q) begin
					kind_d      = KIND_END;
					cmd.op      = OP_SIZE_CLR;
					cmd.sel_end = 1'b1;
					phase_d     = PH_TYPE;
				end else if (data_byte == BYTE_DATA && started_q) begin
					kind_d  = KIND_DATA;
					phase_d = PH_SEQ;
				end else begin
					kind_d  = KIND_IGNORED;
					phase_d = PH_SKIP;
				end
			end
			PH_TYPE: begin
				ftype_d = data_byte;
				phase_d = PH_LEN;
			end
			PH_LEN: begin
				left_d = {8'h00, data_byte};
				if (ftype_q == FTYPE_SIZE) begin
					cmd.op = OP_SIZE_CLR;
				end
				phase_d = (data_byte != 8'h00) ? PH_VAL : PH_TYPE;
			end
			PH_VAL: begin
				if (ftype_q == FTYPE_SIZE) begin
					cmd.op = OP_SIZE_SHIFT;
				end else if (ftype_q == FTYPE_NAME) begin
					cmd.op = OP_NAME;
				end
				left_d = left_dec;
				if (left_dec == 16'd0) begin
					phase_d = PH_TYPE;
				end
			end
			PH_SEQ: begin
				cmd.op  = OP_SEQ;
				phase_d = PH_LHI;
			end
			PH_LHI: begin
				left_d  = {data_byte, 8'h00};
				phase_d = PH_LLO;
			end
			PH_LLO: begin
				left_d  = left_or;
				phase_d = (left_or != 16'd0) ? PH_PAY : PH_SKIP;
			end
			PH_PAY: begin
				cmd.op = OP_PAY;
				left_d = left_dec;
				if (left_dec == 16'd0) begin
					phase_d = PH_SKIP;
				end
			end
			PH_SKIP, PH_DONE: begin
			end
			default: begin
				phase_d = PH_KIND;
			end
		endcase

		// packet close; once the end packet has closed nothing moves again
		if (phase_q != PH_DONE) begin
			cmd.kind = kind_d;
			if (end_of_packet) begin
				phase_d = PH_KIND;
				if (kind_d != KIND_IGNORED) begin
					cmd.done      = 1'b1;
					cmd.data_done = (kind_d == KIND_DATA);
					if (kind_d == KIND_END) begin
						cmd.end_done = 1'b1;
						phase_d      = PH_DONE;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_KIND;
			started_q <= 1'b0;
			kind_q    <= KIND_IGNORED;
			ftype_q   <= 8'h00;
			left_q    <= 16'd0;
		end else if (accept) begin
			phase_q   <= phase_d;
			started_q <= started_d;
			kind_q    <= kind_d;
			ftype_q   <= ftype_d;
			left_q    <= left_d;
		end
	end

endmodule

// ===== design/ftpp_back.sv =====
`timescale 1ns / 1ps
// Back end: applies commands to the size, sequence and count registers
// and forms one result per item. Depends on ftpp_pkg.
module ftpp_back
	import ftpp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic advance,
	input  cmd_t cmd,
	output res_t res
);
	logic [31:0] start_size_q, start_size_d;
	logic [31:0] end_size_q, end_size_d;
	logic [7:0]  seq_q, seq_d;
	logic [31:0] total_q, total_d;
	logic [15:0] count_q, count_d;
	logic        mismatch_q, mismatch_d;
	logic        finished_q, finished_d;

	always_comb begin
		start_size_d = start_size_q;
		end_size_d   = end_size_q;
		seq_d        = seq_q;
		total_d      = total_q;
		count_d      = count_q;
		mismatch_d   = mismatch_q;
		finished_d   = finished_q;
		case (cmd.op)
			OP_PAY: begin
				if (total_q != 32'hFFFF_FFFF) begin
					total_d = total_q + 32'd1;
				end
			end
			OP_SIZE_CLR: begin
				if (cmd.sel_end) begin
					end_size_d = 32'd0;
				end else begin
					start_size_d = 32'd0;
				end
			end
			OP_SIZE_SHIFT: begin
				if (cmd.sel_end) begin
					end_size_d = {end_size_q[23:0], cmd.data};
				end else begin
					start_size_d = {start_size_q[23:0], cmd.data};
				end
			end
			OP_SEQ: begin
				seq_d = cmd.data;
			end
			default: begin
			end
		endcase
		if (cmd.data_done && count_q != 16'hFFFF) begin
			count_d = count_q + 16'd1;
		end
		// size check sees this item's own size update
		if (cmd.end_done) begin
			mismatch_d = (start_size_d != end_size_d);
			finished_d = 1'b1;
		end

		res.payload_valid    = (cmd.op == OP_PAY);
		res.payload_byte     = (cmd.op == OP_PAY) ? cmd.data : 8'h00;
		res.name_valid       = (cmd.op == OP_NAME);
		res.name_byte        = (cmd.op == OP_NAME) ? cmd.data : 8'h00;
		res.packet_kind      = cmd.kind;
		res.packet_done      = cmd.done;
		res.sequence_number  = seq_d;
		res.declared_size    = start_size_d;
		res.bytes_received   = total_d;
		res.packets_received = count_d;
		res.size_mismatch    = mismatch_d;
		res.transfer_done    = finished_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_size_q <= 32'd0;
			end_size_q   <= 32'd0;
			seq_q        <= 8'h00;
			total_q      <= 32'd0;
			count_q      <= 16'd0;
			mismatch_q   <= 1'b0;
			finished_q   <= 1'b0;
		end else if (advance) begin
			start_size_q <= start_size_d;
			end_size_q   <= end_size_d;
			seq_q        <= seq_d;
			total_q      <= total_d;
			count_q      <= count_d;
			mismatch_q   <= mismatch_d;
			finished_q   <= finished_d;
		end
	end

endmodule

// ===== design/file_transfer_packet_parser_unit.sv =====
`timescale 1ns / 1ps
// Top level of the file transfer packet parser: front end, command queue,
// back end and result queue. Depends on ftpp_pkg, ftpp_front, ftpp_fifo, ftpp_back.
//
// channel   handshake        payload
// input     push / full      data_byte, end_of_packet
// result    empty / pop      payload_valid .. transfer_done (one result per item)
//
// One item a cycle sustained while the result queue is popped; each item
// gives one result, via the command queue, then the back end into the result queue.
// The front state machine decides each byte in the cycle it is taken; the
// back end holds the sizes and counters and drains one command a cycle while the result queue has room.
// full rises only when the command queue is full; a stalled pop backs up
// the result queue, then the command queue. Reset clears both queues and state.
module file_transfer_packet_parser_unit
	import ftpp_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        end_of_packet,
	input  logic        pop,
	output logic        empty,
	output logic        payload_valid,
	output logic [7:0]  payload_byte,
	output logic        name_valid,
	output logic [7:0]  name_byte,
	output logic [1:0]  packet_kind,
	output logic        packet_done,
	output logic [7:0]  sequence_number,
	output logic [31:0] declared_size,
	output logic [31:0] bytes_received,
	output logic [15:0] packets_received,
	output logic        size_mismatch,
	output logic        transfer_done
);
	logic accept;
	cmd_t front_cmd, back_cmd;
	logic cmd_empty;
	logic res_full;
	logic advance;
	res_t back_res, out_res;

	assign accept  = push && !full;
	assign advance = !cmd_empty && !res_full;

	ftpp_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.data_byte     (data_byte),
		.end_of_packet (end_of_packet),
		.cmd           (front_cmd)
	);

	ftpp_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.wdata  (front_cmd),
		.full   (full),
		.pop    (advance),
		.rdata  (back_cmd),
		.empty  (cmd_empty)
	);

	ftpp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.cmd     (back_cmd),
		.res     (back_res)
	);

	ftpp_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (advance),
		.wdata  (back_res),
		.full   (res_full),
		.pop    (pop),
		.rdata  (out_res),
		.empty  (empty)
	);

	assign payload_valid    = out_res.payload_valid;
	assign payload_byte     = out_res.payload_byte;
	assign name_valid       = out_res.name_valid;
	assign name_byte        = out_res.name_byte;
	assign packet_kind      = out_res.packet_kind;
	assign packet_done      = out_res.packet_done;
	assign sequence_number  = out_res.sequence_number;
	assign declared_size    = out_res.declared_size;
	assign bytes_received   = out_res.bytes_received;
	assign packets_received = out_res.packets_received;
	assign size_mismatch    = out_res.size_mismatch;
	assign transfer_done    = out_res.transfer_done;

endmodule
